### hw/rtl/utt_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`default_nettype none

package utt_pkg;

   // Result kinds on the response channel
   typedef enum logic [1:0] {
      KIND_UNIT  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // One result item
   typedef struct packed {
      logic [15:0] code_unit;
      kind_type    kind;
      logic [15:0] units_written;
      logic        last;
   } result_type;

   // Most results one input byte can cause (surrogate pair plus status)
   localparam int MAX_RESULTS = 3;

   // Result queue geometry
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Capacity after reset
   localparam logic [15:0] CAPACITY_RESET = 16'd4096;

   // Code point and surrogate constants
   localparam logic [21:0] SUPPLEMENTARY_BASE = 22'h010000;
   localparam logic [15:0] HIGH_SURROGATE     = 16'hD800;
   localparam logic [15:0] LOW_SURROGATE      = 16'hDC00;

endpackage

`default_nettype wire

### hw/rtl/utt_decode.sv
// Per-byte UTF-8 decoder with string state; produces up to three results per byte.
`default_nettype none

module utt_decode (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          in_byte,
   input  wire logic                end_of_input,
   input  wire logic [15:0]         capacity,
   output logic [1:0]               push_count,
   output utt_pkg::result_type      push_data [utt_pkg::MAX_RESULTS]
);

   logic [1:0]  bytes_pending_ff, bytes_pending_in;
   logic [21:0] code_accumulator_ff, code_accumulator_in;
   logic [15:0] unit_count_ff, unit_count_in;
   logic        discarding_ff, discarding_in;

   utt_pkg::result_type res [utt_pkg::MAX_RESULTS];
   logic [1:0]          res_n;

   // Decode one byte against the current string state
   always_comb begin
      logic        err;
      logic        done;
      logic [21:0] cp;
      logic [21:0] addend;
      logic [1:0]  pend_dec;
      logic [16:0] need_sum;
      logic [21:0] v;
      logic        need_two;

      err      = 1'b0;
      done     = 1'b0;
      cp       = '0;
      addend   = '0;
      pend_dec = 2'd0;
      need_sum = '0;
      v        = '0;
      need_two = 1'b0;

      bytes_pending_in    = bytes_pending_ff;
      code_accumulator_in = code_accumulator_ff;
      unit_count_in       = unit_count_ff;
      discarding_in       = discarding_ff;
      res_n               = 2'd0;
      for (int i = 0; i < utt_pkg::MAX_RESULTS; i++) begin
         res[i] = '{code_unit: 16'd0, kind: utt_pkg::KIND_UNIT,
                    units_written: 16'd0, last: 1'b0};
      end

      if (discarding_ff) begin
         // Drop bytes until the end of the string
         if (end_of_input) begin
            bytes_pending_in    = 2'd0;
            code_accumulator_in = '0;
            unit_count_in       = '0;
            discarding_in       = 1'b0;
         end
      end else begin
         // Classify the byte
         if (bytes_pending_ff == 2'd0) begin
            if (!in_byte[7]) begin
               cp   = {14'd0, in_byte};
               done = 1'b1;
            end else if (!in_byte[6]) begin
               err = 1'b1;
            end else if (!in_byte[5]) begin
               code_accumulator_in = {11'd0, in_byte[4:0], 6'd0};
               bytes_pending_in    = 2'd1;
            end else if (!in_byte[4]) begin
               code_accumulator_in = {6'd0, in_byte[3:0], 12'd0};
               bytes_pending_in    = 2'd2;
            end else begin
               code_accumulator_in = {in_byte[3:0], 18'd0};
               bytes_pending_in    = 2'd3;
            end
         end else if (in_byte[7:6] == 2'b10) begin
            pend_dec = bytes_pending_ff - 2'd1;
            case (pend_dec)
               2'd0:    addend = {16'd0, in_byte[5:0]};
               2'd1:    addend = {10'd0, in_byte[5:0], 6'd0};
               2'd2:    addend = {4'd0, in_byte[5:0], 12'd0};
               default: addend = {in_byte[3:0], 18'd0};
            endcase
            bytes_pending_in    = pend_dec;
            code_accumulator_in = code_accumulator_ff + addend;
            if (pend_dec == 2'd0) begin
               cp                  = code_accumulator_in;
               code_accumulator_in = '0;
               done                = 1'b1;
            end
         end else begin
            err = 1'b1;
         end

         // Emit one unit or a surrogate pair, within capacity
         if (!err && done) begin
            need_two = (cp >= utt_pkg::SUPPLEMENTARY_BASE);
            need_sum = {1'b0, unit_count_ff} + (need_two ? 17'd2 : 17'd1);
            if (need_sum > {1'b0, capacity}) begin
               err = 1'b1;
            end else if (!need_two) begin
               unit_count_in = unit_count_ff + 16'd1;
               res[0] = '{code_unit: cp[15:0], kind: utt_pkg::KIND_UNIT,
                          units_written: unit_count_in, last: 1'b0};
               res_n = 2'd1;
            end else begin
               v = cp - utt_pkg::SUPPLEMENTARY_BASE;
               unit_count_in = unit_count_ff + 16'd2;
               res[0] = '{code_unit: utt_pkg::HIGH_SURROGATE + {6'd0, v[19:10]},
                          kind: utt_pkg::KIND_UNIT,
                          units_written: unit_count_ff + 16'd1, last: 1'b0};
               res[1] = '{code_unit: utt_pkg::LOW_SURROGATE + {6'd0, v[9:0]},
                          kind: utt_pkg::KIND_UNIT,
                          units_written: unit_count_in, last: 1'b0};
               res_n = 2'd2;
            end
         end

         // A sequence cut short by the end of the string
         if (!err && end_of_input && bytes_pending_in != 2'd0) begin
            err = 1'b1;
         end

         // Append the status result and settle string state
         if (err) begin
            res[res_n] = '{code_unit: 16'd0, kind: utt_pkg::KIND_ERROR,
                           units_written: unit_count_in, last: 1'b0};
            res_n = res_n + 2'd1;
            bytes_pending_in    = 2'd0;
            code_accumulator_in = '0;
            if (end_of_input) begin
               unit_count_in = '0;
               discarding_in = 1'b0;
            end else begin
               discarding_in = 1'b1;
            end
         end else if (end_of_input) begin
            res[res_n] = '{code_unit: 16'd0, kind: utt_pkg::KIND_DONE,
                           units_written: unit_count_in, last: 1'b0};
            res_n = res_n + 2'd1;
            bytes_pending_in    = 2'd0;
            code_accumulator_in = '0;
            unit_count_in       = '0;
            discarding_in       = 1'b0;
         end
      end

      // Mark the final result of this byte
      for (int i = 0; i < utt_pkg::MAX_RESULTS; i++) begin
         res[i].last = (2'(i + 1) == res_n);
      end
   end

   // Advance string state on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_pending_ff    <= 2'd0;
         code_accumulator_ff <= '0;
         unit_count_ff       <= '0;
         discarding_ff       <= 1'b0;
      end else if (accept) begin
         bytes_pending_ff    <= bytes_pending_in;
         code_accumulator_ff <= code_accumulator_in;
         unit_count_ff       <= unit_count_in;
         discarding_ff       <= discarding_in;
      end
   end

   assign push_count = accept ? res_n : 2'd0;
   assign push_data  = res;

endmodule

`default_nettype wire

### hw/rtl/utt_result_fifo.sv
// Result queue: takes up to three items per cycle, hands out one per cycle when popped.
`default_nettype none

module utt_result_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [1:0]          push_count,
   input  wire utt_pkg::result_type push_data [utt_pkg::MAX_RESULTS],
   input  wire logic                pop,
   output logic                     not_empty,
   output logic                     room,
   output utt_pkg::result_type      head
);

   localparam int AW = utt_pkg::QUEUE_AW;

   utt_pkg::result_type entry_ff [utt_pkg::QUEUE_DEPTH];
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [AW:0]         count_ff, count_in;

   // Pointer and fill arithmetic
   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(push_count);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + (AW+1)'(push_count) - (AW+1)'(pop);
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the new results into consecutive entries
   always_ff @(posedge clock) begin
      for (int i = 0; i < utt_pkg::MAX_RESULTS; i++) begin
         if (2'(i) < push_count) begin
            entry_ff[wr_ptr_ff + AW'(i)] <= push_data[i];
         end
      end
   end

   assign not_empty = (count_ff != '0);
   assign room      = (count_ff <= (AW+1)'(utt_pkg::QUEUE_DEPTH - utt_pkg::MAX_RESULTS));
   assign head      = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### hw/rtl/utf8_to_utf16_transcoder_top.sv
// Top level of the UTF-8 to UTF-16 transcoder.
//
// Takes one UTF-8 byte per cycle while req_stall is low and decodes it in a
// single pass against the string state, producing UTF-16 units (a surrogate
// pair for code points at 0x10000 and above), a success item after the marked
// last byte, or an error item; after an error the rest of the string is
// dropped. Results pass through an 8-entry queue, so a byte is taken every
// cycle as long as the queue has room for three results; the output side
// drains one item per cycle while rsp_stall is low, so sustained input rate
// falls only when bytes keep causing several results. Output capacity is
// written through the csr port; the user must write it only while the block
// is idle, which the block itself does not enforce. It resets to 4096.
`default_nettype none

module utf8_to_utf16_transcoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_code_unit,
   output logic [1:0]       rsp_kind,
   output logic [15:0]      rsp_units_written,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic [15:0]         capacity_ff;
   logic                accept;
   logic                pop;
   logic                room;
   logic [1:0]          push_count;
   utt_pkg::result_type push_data [utt_pkg::MAX_RESULTS];
   utt_pkg::result_type head;

   // Hold the capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= utt_pkg::CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   assign req_stall = !room;
   assign accept    = req_valid && room;
   assign pop       = rsp_valid && !rsp_stall;

   utt_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .capacity     (capacity_ff),
      .push_count   (push_count),
      .push_data    (push_data)
   );

   utt_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (push_data),
      .pop        (pop),
      .not_empty  (rsp_valid),
      .room       (room),
      .head       (head)
   );

   // Drive the result item from the queue head
   assign rsp_code_unit     = head.code_unit;
   assign rsp_kind          = 2'(head.kind);
   assign rsp_units_written = head.units_written;
   assign rsp_last          = head.last;

endmodule

`default_nettype wire
